FILE: rtl/cctlf_pkg.sv
// ----------------------------------------------------------------------------
// cctlf_pkg
// Shared types and constants of the tunable-white LED fade controller:
// beat payloads, command codes, controller states and the control/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cctlf_pkg;

  // Field and register widths
  localparam int CMD_W     = 2;
  localparam int VALUE_W   = 16;
  localparam int DUTY_W    = 10;
  localparam int UI_W      = 6;
  localparam int FS_W      = 14;
  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 1;
  localparam int TICK_W    = 8;
  localparam int BRIGHT_W  = 7;
  localparam int TEMP_W    = 16;
  localparam int B10_W     = 10;
  localparam int DIV_DVW   = 15;
  localparam int PROD_W    = B10_W + DIV_DVW;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_INTERVAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLANK_STEPS     = 1'd1;

  // Register reset values
  localparam int UI_RESET = 1;
  localparam int FS_RESET = 20;

  // Brightness and mixing constants
  localparam int BRIGHT_MAX    = 100;
  localparam int BRIGHT_SCALE  = 10;
  localparam int PERMILLE_FULL = 1000;

  // Colour temperature range
  localparam int TEMP_LOW  = 153;
  localparam int TEMP_HIGH = 500;
  localparam int TEMP_MID  = (TEMP_HIGH + TEMP_LOW) / 2;
  localparam int TEMP_HALF = (TEMP_HIGH - TEMP_LOW) / 2;
  localparam bit HALF_POS  = (TEMP_HALF > 0);
  localparam int HALF_RND  = HALF_POS ? TEMP_HALF / 2 : 0;
  localparam int HALF_DIV  = HALF_POS ? TEMP_HALF : 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_ONOFF  = 2'd1,
    CMD_BRIGHT = 2'd2,
    CMD_TEMP   = 2'd3
  } cctlf_cmd_code_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
  } cctlf_in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] cold_permille;
    logic [DUTY_W-1:0] warm_permille;
  } cctlf_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MIX,
    ST_SCL_GO,
    ST_SCL_WAIT,
    ST_CST_GO,
    ST_CST_WAIT,
    ST_WST_GO,
    ST_WST_WAIT,
    ST_EMIT
  } cctlf_state_t;

  typedef enum logic [1:0] {
    DSEL_SCALE,
    DSEL_COLD,
    DSEL_WARM
  } cctlf_dsel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic        capture;
    logic        apply_set;
    logic        tick_reload;
    logic        tick_bump;
    logic        tick_clear;
    logic        mix;
    logic        div_start;
    cctlf_dsel_t dsel;
    logic        scl_load;
    logic        cst_load;
    logic        wst_load;
    logic        emit;
  } cctlf_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    cctlf_cmd_code_t cmd_code;
    logic            at_target;
    logic            tick_due;
    logic            onoff_noop;
    logic            off_zero;
    logic            div_busy;
    logic            div_done;
    logic            out_free;
  } cctlf_sts_t;

endpackage

`default_nettype wire

FILE: rtl/cctlf_div.sv
// ----------------------------------------------------------------------------
// cctlf_div
// Unsigned restoring divider, two quotient bits per cycle. Pulses done for
// one cycle when the quotient is ready; the quotient holds until next start.
// ----------------------------------------------------------------------------
`default_nettype none

module cctlf_div
  import cctlf_pkg::*;
#(
  parameter int DW  = 34,
  parameter int DVW = 15
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [DW-1:0]  dividend,
  input  wire logic [DVW-1:0] divisor,
  output logic                busy,
  output logic                done,
  output logic [DW-1:0]       quotient
);

  localparam int STEPS = DW / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [DW-1:0]    quo_r, quo_nxt;
  logic [DVW-1:0]   rem_r, rem_nxt;
  logic [DVW-1:0]   dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;

  // Two restoring steps per cycle
  always_comb begin
    logic [DVW:0] trial;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    for (int i = 0; i < 2; i++) begin
      trial   = {rem_nxt, quo_nxt[DW-1]};
      quo_nxt = {quo_nxt[DW-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt    = DVW'(trial - {1'b0, dvs_r});
        quo_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[DVW-1:0];
      end
    end
  end

  // Hold operands and partial results
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  // Count iterations and flag completion
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

FILE: rtl/cctlf_dp.sv
// ----------------------------------------------------------------------------
// cctlf_dp
// Datapath: configuration, brightness and temperature state, target mixing,
// step computation on the shared divider, fade stepping and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cctlf_dp
  import cctlf_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire cctlf_in_t            in_data,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output cctlf_out_t                out_data,
  input  wire cctlf_ctl_t           ctl,
  output cctlf_sts_t                sts
);

  localparam int VW       = 11 + FRAC_BITS;
  localparam int DFW      = VW + 1;
  localparam int DIV_W    = 26 + FRAC_BITS + (FRAC_BITS % 2);
  localparam int HALF_LSB = 1 << (FRAC_BITS - 1);
  localparam int FULL_Q   = PERMILLE_FULL << FRAC_BITS;
  localparam logic signed [VW-1:0] FULL_V = VW'(FULL_Q);

  // Configuration and item registers
  logic [UI_W-1:0]     ui_r;
  logic [FS_W-1:0]     fs_r;
  cctlf_in_t           item_r;

  // Control state
  logic [TICK_W-1:0]   tick_r;
  logic [BRIGHT_W-1:0] bright_r, last_on_r;
  logic [TEMP_W-1:0]   temp_r;
  logic signed [VW-1:0] cold_now_r, warm_now_r, cold_tgt_r, warm_tgt_r;
  logic signed [VW-1:0] cold_step_r, warm_step_r;
  logic                out_valid_r;

  // Working registers
  logic signed [VW-1:0] new_c_r, new_w_r;
  logic [PROD_W-1:0]    prod_r;
  cctlf_out_t           out_data_r;

  // Combinational terms
  logic [UI_W-1:0]      ui_eff;
  logic [FS_W-1:0]      fs_eff;
  logic [TICK_W-1:0]    tick_inc;
  logic [BRIGHT_W-1:0]  bright_set;
  logic [TEMP_W-1:0]    temp_hi, temp_set;
  logic signed [17:0]   off;
  logic [16:0]          abs_off;
  logic                 off_zero, off_pos;
  logic [DIV_DVW-1:0]   num;
  logic [B10_W-1:0]     b10;
  logic signed [VW-1:0] full;
  logic [PROD_W-1:0]    prod;
  logic signed [DFW-1:0] diff_c, diff_w;
  logic [VW-1:0]        mag_c, mag_w;
  logic [DIV_W-1:0]     div_dividend, div_quo;
  logic [DIV_DVW-1:0]   div_divisor;
  logic                 div_busy, div_done;
  logic [VW-1:0]        quo_v;
  logic signed [VW-1:0] adv_c, adv_w;
  logic                 out_free;

  // Move one step toward target without overshoot
  function automatic logic signed [VW-1:0] adv(input logic signed [VW-1:0] now,
                                               input logic signed [VW-1:0] tgt,
                                               input logic signed [VW-1:0] stp);
    logic signed [DFW-1:0] gap;
    logic signed [DFW-1:0] sum;
    logic signed [VW-1:0]  res;
    gap = DFW'(tgt) - DFW'(now);
    sum = DFW'(now) + DFW'(stp);
    if (stp > 0) begin
      res = (gap > DFW'(stp)) ? sum[VW-1:0] : tgt;
    end else if (stp < 0) begin
      res = (gap < DFW'(stp)) ? sum[VW-1:0] : tgt;
    end else begin
      res = now;
    end
    return res;
  endfunction

  // Round a fixed-point value to whole permille
  function automatic logic [DUTY_W-1:0] duty(input logic signed [VW-1:0] v);
    logic [VW-1:0] sum;
    sum = VW'($unsigned(v)) + VW'(HALF_LSB);
    return v[VW-1] ? '0 : sum[FRAC_BITS +: DUTY_W];
  endfunction

  // Signed step from rounded quotient; never zero for a nonzero difference
  function automatic logic signed [VW-1:0] mk_step(input logic signed [DFW-1:0] diff,
                                                   input logic [VW-1:0] q);
    logic [VW-1:0] qs;
    qs = (q == '0 && diff != '0) ? VW'(1) : q;
    return diff[DFW-1] ? -qs : qs;
  endfunction

  // Tick bookkeeping terms
  assign ui_eff   = (ui_r == '0) ? UI_W'(1) : ui_r;
  assign fs_eff   = (fs_r == '0) ? FS_W'(1) : fs_r;
  assign tick_inc = tick_r + TICK_W'(1);

  // Clamp incoming brightness and temperature
  assign temp_hi  = (item_r.value > TEMP_W'(TEMP_HIGH)) ? TEMP_W'(TEMP_HIGH) : item_r.value;
  assign temp_set = (temp_hi < TEMP_W'(TEMP_LOW)) ? TEMP_W'(TEMP_LOW) : temp_hi;

  always_comb begin
    unique case (cctlf_cmd_code_t'(item_r.cmd))
      CMD_ONOFF:  bright_set = item_r.value[0] ? last_on_r : '0;
      CMD_BRIGHT: bright_set = (item_r.value > VALUE_W'(BRIGHT_MAX)) ?
                               BRIGHT_W'(BRIGHT_MAX) : item_r.value[BRIGHT_W-1:0];
      default:    bright_set = bright_r;
    endcase
  end

  // Mix: offset from midpoint, scale numerator, full-scale target
  assign off      = $signed({2'b00, temp_r}) - 18'(TEMP_MID);
  assign abs_off  = off[17] ? 17'(-off) : off[16:0];
  assign off_zero = (off == '0);
  assign off_pos  = !off[17] && !off_zero;
  assign num      = (HALF_POS && abs_off < 17'(HALF_DIV)) ?
                    DIV_DVW'(17'(HALF_DIV) - abs_off) : '0;
  assign b10      = B10_W'({3'b000, bright_r} * B10_W'(BRIGHT_SCALE));
  assign full     = VW'({b10, {FRAC_BITS{1'b0}}});
  assign prod     = PROD_W'(b10 * num);

  // Step differences against current targets
  assign diff_c = DFW'(new_c_r) - DFW'(cold_tgt_r);
  assign diff_w = DFW'(new_w_r) - DFW'(warm_tgt_r);
  assign mag_c  = diff_c[DFW-1] ? VW'(-diff_c) : diff_c[VW-1:0];
  assign mag_w  = diff_w[DFW-1] ? VW'(-diff_w) : diff_w[VW-1:0];

  // Select divider operands
  always_comb begin
    unique case (ctl.dsel)
      DSEL_SCALE: begin
        div_dividend = DIV_W'({prod_r, {FRAC_BITS{1'b0}}}) + DIV_W'(HALF_RND);
        div_divisor  = DIV_DVW'(HALF_DIV);
      end
      DSEL_WARM: begin
        div_dividend = DIV_W'(mag_w) + DIV_W'(fs_eff >> 1);
        div_divisor  = DIV_DVW'(fs_eff);
      end
      default: begin
        div_dividend = DIV_W'(mag_c) + DIV_W'(fs_eff >> 1);
        div_divisor  = DIV_DVW'(fs_eff);
      end
    endcase
  end

  cctlf_div #(
    .DW  (DIV_W),
    .DVW (DIV_DVW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign quo_v = div_quo[VW-1:0];

  // Fade step candidates
  assign adv_c    = adv(cold_now_r, cold_tgt_r, cold_step_r);
  assign adv_w    = adv(warm_now_r, warm_tgt_r, warm_step_r);
  assign out_free = !out_valid_r || out_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ui_r <= UI_W'(UI_RESET);
      fs_r <= FS_W'(FS_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_UPDATE_INTERVAL: ui_r <= cfg_wdata[UI_W-1:0];
        REG_FLANK_STEPS:     fs_r <= cfg_wdata[FS_W-1:0];
      endcase
    end
  end

  // Control state: tick, brightness, temperature, fade, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= TICK_W'(UI_RESET);
      bright_r    <= '0;
      last_on_r   <= BRIGHT_W'(BRIGHT_MAX);
      temp_r      <= TEMP_W'(TEMP_MID);
      cold_now_r  <= '0;
      warm_now_r  <= '0;
      cold_tgt_r  <= '0;
      warm_tgt_r  <= '0;
      cold_step_r <= '0;
      warm_step_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.tick_reload) tick_r <= TICK_W'(ui_eff);
      if (ctl.tick_bump)   tick_r <= tick_inc;
      if (ctl.tick_clear)  tick_r <= '0;
      if (ctl.apply_set) begin
        if (cctlf_cmd_code_t'(item_r.cmd) == CMD_TEMP) begin
          temp_r <= temp_set;
        end else begin
          bright_r <= bright_set;
        end
      end
      if (ctl.mix && bright_r != '0) last_on_r <= bright_r;
      if (ctl.cst_load) begin
        cold_step_r <= mk_step(diff_c, quo_v);
        cold_tgt_r  <= new_c_r;
      end
      if (ctl.wst_load) begin
        warm_step_r <= mk_step(diff_w, quo_v);
        warm_tgt_r  <= new_w_r;
      end
      if (ctl.emit) begin
        cold_now_r  <= adv_c;
        warm_now_r  <= adv_w;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: captured item, mixed targets, product, result beat
  always_ff @(posedge clk) begin
    if (ctl.capture) item_r <= in_data;
    if (ctl.mix) begin
      // Drop the scaled channel when there is no half range to scale over
      new_c_r <= (!off_zero && !HALF_POS && off_pos) ? '0 : full;
      new_w_r <= (!off_zero && !HALF_POS && !off_pos) ? '0 : full;
      prod_r  <= prod;
    end
    if (ctl.scl_load) begin
      if (off_pos) new_c_r <= quo_v;
      else         new_w_r <= quo_v;
    end
    if (ctl.emit) begin
      out_data_r.cold_permille <= duty(adv_c);
      out_data_r.warm_permille <= duty(adv_w);
    end
  end

  // Status to controller
  always_comb begin
    sts.cmd_code   = cctlf_cmd_code_t'(item_r.cmd);
    sts.at_target  = (cold_now_r == cold_tgt_r) && (warm_now_r == warm_tgt_r);
    sts.tick_due   = (tick_inc >= TICK_W'(ui_eff));
    sts.onoff_noop = item_r.value[0] ? (bright_r != '0) : (bright_r == '0);
    sts.off_zero   = off_zero;
    sts.div_busy   = div_busy;
    sts.div_done   = div_done;
    sts.out_free   = out_free;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A fade step always leaves a result beat pending
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |=> out_valid_r)
    else $error("result beat not raised after fade step");

  // Current values stay within full scale
  a_now_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cold_now_r <= FULL_V) && (warm_now_r <= FULL_V) &&
    (cold_now_r >= 0) && (warm_now_r >= 0))
    else $error("channel value outside full scale");

endmodule

`default_nettype wire

FILE: rtl/cctlf_ctrl.sv
// ----------------------------------------------------------------------------
// cctlf_ctrl
// Controller: accepts one beat at a time, decodes the command and sequences
// the datapath through mixing, divider runs and fade steps.
// ----------------------------------------------------------------------------
`default_nettype none

module cctlf_ctrl
  import cctlf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire cctlf_sts_t sts,
  output cctlf_ctl_t      ctl
);

  cctlf_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    ctl.dsel  = DSEL_COLD;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts.cmd_code) inside
          CMD_TICK: begin
            if (sts.at_target) begin
              ctl.tick_reload = 1'b1;
              state_nxt       = ST_IDLE;
            end else if (sts.tick_due) begin
              ctl.tick_clear = 1'b1;
              state_nxt      = ST_EMIT;
            end else begin
              ctl.tick_bump = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end
          CMD_ONOFF: begin
            if (sts.onoff_noop) begin
              state_nxt = ST_IDLE;
            end else begin
              ctl.apply_set = 1'b1;
              state_nxt     = ST_MIX;
            end
          end
          CMD_BRIGHT, CMD_TEMP: begin
            ctl.apply_set = 1'b1;
            state_nxt     = ST_MIX;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_MIX: begin
        ctl.mix   = 1'b1;
        state_nxt = (sts.off_zero || !HALF_POS) ? ST_CST_GO : ST_SCL_GO;
      end
      ST_SCL_GO: begin
        ctl.div_start = 1'b1;
        ctl.dsel      = DSEL_SCALE;
        state_nxt     = ST_SCL_WAIT;
      end
      ST_SCL_WAIT: begin
        ctl.dsel = DSEL_SCALE;
        if (sts.div_done) begin
          ctl.scl_load = 1'b1;
          state_nxt    = ST_CST_GO;
        end
      end
      ST_CST_GO: begin
        ctl.div_start = 1'b1;
        ctl.dsel      = DSEL_COLD;
        state_nxt     = ST_CST_WAIT;
      end
      ST_CST_WAIT: begin
        ctl.dsel = DSEL_COLD;
        if (sts.div_done) begin
          ctl.cst_load = 1'b1;
          state_nxt    = ST_WST_GO;
        end
      end
      ST_WST_GO: begin
        ctl.div_start = 1'b1;
        ctl.dsel      = DSEL_WARM;
        state_nxt     = ST_WST_WAIT;
      end
      ST_WST_WAIT: begin
        ctl.dsel = DSEL_WARM;
        if (sts.div_done) begin
          ctl.wst_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          ctl.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Divider is never left running when a new beat can enter
  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !sts.div_busy)
    else $error("divider busy while idle");

  // Fade step only into a free result slot
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> sts.out_free)
    else $error("fade step would overwrite pending result");

  // Divider completion only seen while waiting on it
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == ST_SCL_WAIT || state_r == ST_CST_WAIT ||
                      state_r == ST_WST_WAIT))
    else $error("divider result arrived outside a wait state");

endmodule

`default_nettype wire

FILE: rtl/cct_led_fade_controller_top.sv
// ----------------------------------------------------------------------------
// cct_led_fade_controller_top
// Tunable-white LED dimmer with linear fade between brightness/temperature
// settings.
//
// Input channel (in_valid/in_ready/in_data) takes one command beat: a timer
// tick, on/off, brightness percent or colour temperature. Result channel
// (out_valid/out_ready/out_data) carries the rounded cold and warm duties in
// permille, one beat per fade step only. The cfg_ port writes
// update_interval (index 0) and flank_steps (index 1). Beats are taken one
// at a time. A set command runs the shared divider (two quotient bits per
// cycle) up to three times: one scale division, skipped when the
// temperature sits at the midpoint, and two step divisions.
// The result register parts the two channels: new beats are accepted while
// a result waits; a tick that needs a fade step waits only if the previous
// result is still untaken. Reset (rst_n low, synchronous) restores the
// register defaults, dark outputs, midpoint temperature and full last-on
// brightness; no result is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cct_led_fade_controller_top
  import cctlf_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire cctlf_in_t            in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output cctlf_out_t                out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  cctlf_ctl_t ctl;
  cctlf_sts_t sts;

  // Sequencer
  cctlf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // State, arithmetic and result register
  cctlf_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule

`default_nettype wire

FILE: test/tb_cct_led_fade_controller_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cct_led_fade_controller_top
// Self-checking bench for the tunable-white LED fade controller. A queue of
// command beats feeds a valid/ready driver, and every accepted beat goes
// through a cycle-free model of the dimmer that predicts the duty beats.
// A monitor compares each duty beat with the oldest prediction. A directed
// opening covers clamping, on/off restore and no-op cases. Six random phases
// follow, each under its own update_interval/flank_steps setting, with
// varying sender idling and receiver back-pressure.
// ----------------------------------------------------------------------------

module tb_cct_led_fade_controller_top;
  import cctlf_pkg::*;

  localparam int FRAC        = 8;
  localparam int SETTLE      = 100;   // covers a set command (three divisions)
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_BEATS = 225;
  localparam int ONE_Q       = 1 << FRAC;
  localparam int FULL_Q      = PERMILLE_FULL * ONE_Q;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  cctlf_in_t  in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  cctlf_out_t out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_UPDATE_INTERVAL;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  cct_led_fade_controller_top #(.FRAC_BITS(FRAC)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Dimmer model state (targets, currents and steps in Q.FRAC permille)
  logic [UI_W-1:0]     ui_reg = UI_RESET[UI_W-1:0];
  logic [FS_W-1:0]     fs_reg = FS_RESET[FS_W-1:0];
  int                  cold_now = 0, warm_now = 0;
  int                  cold_tgt = 0, warm_tgt = 0;
  int                  cold_step = 0, warm_step = 0;
  logic [TICK_W-1:0]   tick_cnt = UI_RESET[TICK_W-1:0];
  logic [BRIGHT_W-1:0] bright = '0;
  logic [BRIGHT_W-1:0] last_on_bright = BRIGHT_MAX[BRIGHT_W-1:0];
  logic [TEMP_W-1:0]   colour_temp = TEMP_MID[TEMP_W-1:0];

  cctlf_in_t  cmd_pending_q[$];
  cctlf_out_t duty_expect_q[$];
  cctlf_out_t duty_exp;

  int sender_idle_pct = 11;
  int recv_stall_pct  = 63;
  int mismatch_count  = 0;
  int idle_cycles     = 0;
  int phase_beats     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Scale a full channel down by the distance of the temperature from the midpoint
  function automatic int scale_channel(int full_q, int off);
    int num;
    if (TEMP_HALF <= 0) return 0;
    num = TEMP_HALF - ((off < 0) ? -off : off);
    if (num < 0) num = 0;
    if (num > TEMP_HALF) num = TEMP_HALF;
    return (full_q * num + TEMP_HALF / 2) / TEMP_HALF;
  endfunction

  // Per-step increment: rounded quotient, never zero for a nonzero distance
  function automatic int fade_increment(int diff);
    int fs_eff;
    int mag;
    int q;
    fs_eff = (fs_reg == 0) ? 1 : int'(fs_reg);
    mag = (diff < 0) ? -diff : diff;
    q = (mag + fs_eff / 2) / fs_eff;
    if (q == 0 && mag != 0) q = 1;
    return (diff < 0) ? -q : q;
  endfunction

  function automatic int fade_toward(int now, int tgt, int step);
    if (step > 0) return (tgt - now > step) ? now + step : tgt;
    if (step < 0) return (tgt - now < step) ? now + step : tgt;
    return now;
  endfunction

  function automatic logic [DUTY_W-1:0] to_duty(int v);
    if (v < 0) v = 0;
    return DUTY_W'((v + ONE_Q / 2) >>> FRAC);
  endfunction

  // Remix brightness and temperature into new targets and fade steps
  task automatic remix_targets();
    int full_q;
    int c;
    int w;
    int off;
    if (bright > 0) last_on_bright = bright;
    full_q = int'(bright) * BRIGHT_SCALE * ONE_Q;
    c = full_q;
    w = full_q;
    off = int'(colour_temp) - TEMP_MID;
    if (off > 0) c = scale_channel(full_q, off);
    else if (off < 0) w = scale_channel(full_q, off);
    if (c > FULL_Q) c = FULL_Q;
    if (w > FULL_Q) w = FULL_Q;
    cold_step = fade_increment(c - cold_tgt);
    warm_step = fade_increment(w - warm_tgt);
    cold_tgt = c;
    warm_tgt = w;
  endtask

  // Apply one accepted command beat and queue any duty beat it causes
  task automatic apply_dimmer_cmd(input cctlf_in_t beat);
    int ui_eff;
    int t;
    cctlf_out_t r;
    ui_eff = (ui_reg == 0) ? 1 : int'(ui_reg);
    case (cctlf_cmd_code_t'(beat.cmd))
      CMD_TICK: begin
        if (cold_now == cold_tgt && warm_now == warm_tgt) begin
          tick_cnt = TICK_W'(ui_eff);
        end else begin
          tick_cnt = tick_cnt + 1'b1;
          if (int'(tick_cnt) >= ui_eff) begin
            tick_cnt = '0;
            cold_now = fade_toward(cold_now, cold_tgt, cold_step);
            warm_now = fade_toward(warm_now, warm_tgt, warm_step);
            r.cold_permille = to_duty(cold_now);
            r.warm_permille = to_duty(warm_now);
            duty_expect_q.push_back(r);
          end
        end
      end
      CMD_ONOFF: begin
        if (!beat.value[0] && bright > 0) begin
          bright = '0;
          remix_targets();
        end else if (beat.value[0] && bright == 0) begin
          bright = last_on_bright;
          remix_targets();
        end
      end
      CMD_BRIGHT: begin
        bright = (beat.value > BRIGHT_MAX) ? BRIGHT_MAX[BRIGHT_W-1:0]
                                           : beat.value[BRIGHT_W-1:0];
        remix_targets();
      end
      default: begin
        t = int'(beat.value);
        if (t > TEMP_HIGH) t = TEMP_HIGH;
        if (t < TEMP_LOW) t = TEMP_LOW;
        colour_temp = TEMP_W'(t);
        remix_targets();
      end
    endcase
  endtask

  // Drive command beats from the pending queue, predicting each accepted one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) apply_dimmer_cmd(in_data);
      if (cmd_pending_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= cmd_pending_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Check duty beats against predictions and apply back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (duty_expect_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected duty beat cold=%0d warm=%0d", $realtime,
                     out_data.cold_permille, out_data.warm_permille);
        end else begin
          duty_exp = duty_expect_q.pop_front();
          if (out_data.cold_permille !== duty_exp.cold_permille ||
              out_data.warm_permille !== duty_exp.warm_permille) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: duty mismatch cold exp=%0d got=%0d, warm exp=%0d got=%0d",
                       $realtime, duty_exp.cold_permille, out_data.cold_permille,
                       duty_exp.warm_permille, out_data.warm_permille);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Abort when no beat moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic queue_cmd(input cctlf_cmd_code_t code, input logic [VALUE_W-1:0] v);
    cctlf_in_t it;
    it.cmd   = code;
    it.value = v;
    cmd_pending_q.push_back(it);
    phase_beats++;
  endtask

  // Hold until every beat is taken and every duty beat has come, then settle
  task automatic wait_quiet();
    while (cmd_pending_q.size() != 0 || in_valid) @(posedge clk);
    while (duty_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == REG_UPDATE_INTERVAL) ui_reg = data[UI_W-1:0];
    else fs_reg = data[FS_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int ui_tab[6];
    int fs_tab[6];
    int ui_eff;
    int pick;
    int burst;
    ui_tab = '{0, 3, 63, 1, 51, 2};
    fs_tab = '{0, 20, 16383, 13107, 1, 7};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening under the reset setting
    queue_cmd(CMD_TICK, 16'h0000);     // at target: reload, no duty
    queue_cmd(CMD_ONOFF, 16'h0000);    // off while off
    queue_cmd(CMD_ONOFF, 16'h0001);    // restore full brightness
    queue_cmd(CMD_ONOFF, 16'hFFFF);    // on while on
    queue_cmd(CMD_TICK, 16'hFFFF);
    queue_cmd(CMD_TICK, 16'hAAAA);
    queue_cmd(CMD_BRIGHT, 16'hFFFF);   // clamp to 100
    queue_cmd(CMD_TEMP, 16'h0000);     // clamp to low end
    queue_cmd(CMD_TICK, 16'h5555);
    queue_cmd(CMD_TICK, 16'h0000);
    queue_cmd(CMD_TEMP, 16'hFFFF);     // clamp to high end
    queue_cmd(CMD_TICK, 16'h0001);
    queue_cmd(CMD_TEMP, TEMP_MID[VALUE_W-1:0]);
    queue_cmd(CMD_BRIGHT, 16'h0001);
    queue_cmd(CMD_TICK, 16'h0000);
    queue_cmd(CMD_BRIGHT, 16'h0000);
    queue_cmd(CMD_TICK, 16'h0000);
    queue_cmd(CMD_ONOFF, 16'h0001);    // restore the last nonzero brightness
    queue_cmd(CMD_ONOFF, 16'hFFFE);    // bit 0 low: off
    queue_cmd(CMD_BRIGHT, 16'd100);
    queue_cmd(CMD_TEMP, TEMP_LOW[VALUE_W-1:0]);
    queue_cmd(CMD_TICK, 16'h0000);
    queue_cmd(CMD_TEMP, TEMP_HIGH[VALUE_W-1:0]);
    queue_cmd(CMD_TICK, 16'h0000);
    queue_cmd(CMD_TICK, 16'h0000);
    wait_quiet();

    for (int ph = 0; ph < 6; ph++) begin
      // Idling pattern: sender light/receiver heavy, then swapped, then none
      sender_idle_pct = (ph < 2) ? 11 : (ph < 4) ? 63 : 0;
      recv_stall_pct  = (ph < 2) ? 63 : (ph < 4) ? 11 : 0;
      write_reg(REG_FLANK_STEPS, CFG_W'(fs_tab[ph]));
      write_reg(REG_UPDATE_INTERVAL, CFG_W'(($urandom_range(255) << UI_W) | ui_tab[ph]));
      ui_eff = (ui_tab[ph] == 0) ? 1 : ui_tab[ph];
      phase_beats = 0;

      // Mostly set commands followed by tick runs, some loose commands as noise
      while (phase_beats < PHASE_BEATS) begin
        pick = $urandom_range(99);
        if (pick < 12) begin
          queue_cmd(CMD_BRIGHT, ($urandom_range(9) == 0) ? VALUE_W'($urandom)
                                                         : VALUE_W'($urandom_range(100)));
        end else if (pick < 22) begin
          queue_cmd(CMD_TEMP, ($urandom_range(7) == 0) ? VALUE_W'($urandom)
                                                       : VALUE_W'($urandom_range(520, 140)));
        end else if (pick < 30) begin
          queue_cmd(CMD_ONOFF, VALUE_W'($urandom));
        end else if (pick < 35) begin
          queue_cmd(CMD_TICK, VALUE_W'($urandom));
        end else begin
          burst = $urandom_range(4 * ui_eff + 4, 1);
          if (burst > PHASE_BEATS - phase_beats) burst = PHASE_BEATS - phase_beats;
          repeat (burst) queue_cmd(CMD_TICK, VALUE_W'($urandom));
        end
        if (cmd_pending_q.size() > 40)
          while (cmd_pending_q.size() > 8) @(posedge clk);
      end
      wait_quiet();
    end

    if (mismatch_count == 0 && duty_expect_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
